// ===== rtl/wapc_pkg.sv =====
// Shared types and constants for the wave absorption piston correction unit.
// Depends on nothing; every other file uses it by scoped names.
`default_nettype none
package wapc_pkg;
  localparam int FracBits = 32;
  localparam int MaxPower = 8;

  localparam logic [2:0] RegStartTime  = 3'd0;
  localparam logic [2:0] RegAbsorbGain = 3'd1;
  localparam logic [2:0] RegHomePos    = 3'd2;
  localparam logic [2:0] RegDriftLimit = 3'd3;
  localparam logic [2:0] RegDriftTime  = 3'd4;
  localparam logic [2:0] RegDriftPower = 3'd5;
  localparam logic [2:0] RegAccelLimit = 3'd6;

  localparam logic signed [47:0] PosMax = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] NegMin = 48'sh8000_0000_0000;
  localparam logic [46:0] AccelUnlimited = 47'h7FFF_FFFF_FFFF;

  typedef struct packed {
    logic [47:0]        sim_time;
    logic [32:0]        step_length;
    logic signed [47:0] planned_move;
    logic signed [47:0] target_elevation;
    logic signed [47:0] measured_elevation;
    logic               disable_correction;
  } in_beat_t;

  typedef struct packed {
    logic signed [47:0] correction;
    logic signed [47:0] piston_position;
    logic               accel_clamped;
    logic               drift_active;
  } out_beat_t;

  typedef struct packed {
    logic [47:0]        start_time;
    logic [46:0]        absorb_gain;
    logic signed [47:0] home_position;
    logic [46:0]        drift_limit;
    logic [47:0]        drift_time;
    logic [3:0]         drift_power;
    logic [46:0]        accel_limit;
  } cfg_t;

  // Saturate a wide signed value to 48 bits.
  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    logic signed [47:0] r;
    if (v > 64'(PosMax)) r = PosMax;
    else if (v < 64'(NegMin)) r = NegMin;
    else r = v[47:0];
    return r;
  endfunction

  // Build a saturated signed result from magnitude, overflow flag and sign.
  function automatic logic signed [47:0] from_mag(input logic [63:0] m,
                                                  input logic over,
                                                  input logic neg);
    logic signed [47:0] r;
    if (neg) begin
      if (over || m > 64'h8000_0000_0000) r = NegMin;
      else r = 48'(-$signed(m));
    end else begin
      if (over || m > 64'(PosMax)) r = PosMax;
      else r = m[47:0];
    end
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/wave_absorption_piston_correction_unit.sv =====
// Top level of the wave absorption piston correction unit: configuration
// registers, handshakes and output register. Uses wapc_pkg, wapc_ctrl, wapc_datapath.
`default_nettype none
// One control step at a time. A step runs two to six divides through a shared
// one-bit-per-cycle 128-step divider and up to 23 multiplies, of which a running
// drift ramp adds two divides and up to 2*(p+1) multiplies. The next beat is
// accepted as soon as the step ends, while the result waits in the output
// register; a step whose result finds that register still occupied holds
// until it drains.
module wave_absorption_piston_correction_unit (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire wapc_pkg::in_beat_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output wapc_pkg::out_beat_t      out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [2:0]          cfg_index_i,
  input  wire logic [47:0]         cfg_data_i
);
  wapc_pkg::cfg_t cfg_q;
  wapc_pkg::out_beat_t res;
  logic busy_q, done, start, full_q;
  logic ms, ds, dbusy;
  logic signed [63:0] ma, da;
  logic [63:0] mb, db;
  logic [5:0] msh;
  logic signed [47:0] dres;

  assign in_ready_o = !busy_q;
  assign start = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_time <= '0; cfg_q.absorb_gain <= '0; cfg_q.home_position <= '0;
      cfg_q.drift_limit <= '0; cfg_q.drift_time <= 48'h1_0000_0000;
      cfg_q.drift_power <= 4'd1; cfg_q.accel_limit <= wapc_pkg::AccelUnlimited;
      busy_q <= 1'b0; full_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          wapc_pkg::RegStartTime:  cfg_q.start_time <= cfg_data_i;
          wapc_pkg::RegAbsorbGain: cfg_q.absorb_gain <= cfg_data_i[46:0];
          wapc_pkg::RegHomePos:    cfg_q.home_position <= cfg_data_i;
          wapc_pkg::RegDriftLimit: cfg_q.drift_limit <= cfg_data_i[46:0];
          wapc_pkg::RegDriftTime:  cfg_q.drift_time <= cfg_data_i;
          wapc_pkg::RegDriftPower: cfg_q.drift_power <= cfg_data_i[3:0];
          wapc_pkg::RegAccelLimit: cfg_q.accel_limit <= cfg_data_i[46:0];
          default: ;
        endcase
      end
      if (start) busy_q <= 1'b1;
      else if (done) busy_q <= 1'b0;
      if (done) full_q <= 1'b1;
      else if (out_ready_i) full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) out_data_o <= res;
  end
  assign out_valid_o = full_q;

  wapc_ctrl u_ctrl (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .home_load_i(cfg_we_i && cfg_index_i == wapc_pkg::RegHomePos),
    .home_value_i(cfg_data_i),
    .start_i(start), .beat_i(in_data_i), .res_free_i(!full_q || out_ready_i),
    .done_o(done), .res_o(res),
    .mul_start_o(ms), .mul_a_o(ma), .mul_b_o(mb), .mul_sh_o(msh),
    .div_start_o(ds), .div_a_o(da), .div_b_o(db), .busy_i(dbusy), .result_i(dres)
  );

  wapc_datapath u_dp (
    .clk_i, .rst_ni, .mul_start_i(ms), .mul_a_i(ma), .mul_b_i(mb), .mul_sh_i(msh),
    .div_start_i(ds), .div_a_i(da), .div_b_i(db), .busy_o(dbusy), .result_o(dres)
  );
endmodule
`default_nettype wire

// ===== rtl/wapc_datapath.sv =====
// Datapath: one shared sequential multiplier and one shared radix-2 divider with
// their operand registers, driven by commands from wapc_ctrl. Uses wapc_pkg.
`default_nettype none
module wapc_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               mul_start_i,
  input  wire logic signed [63:0] mul_a_i,
  input  wire logic [63:0]        mul_b_i,
  input  wire logic [5:0]         mul_sh_i,
  input  wire logic               div_start_i,
  input  wire logic signed [63:0] div_a_i,
  input  wire logic [63:0]        div_b_i,
  output logic                    busy_o,
  output logic signed [47:0]      result_o
);
  // Multiplier: 16 bits of the multiplier per cycle.
  logic [63:0]  mm_q, mm_d;
  logic [63:0]  mb_q, mb_d;
  logic [127:0] acc_q, acc_d;
  logic [2:0]   mcnt_q, mcnt_d;
  logic [5:0]   msh_q, msh_d;
  logic         mneg_q, mneg_d;
  // Divider: one quotient bit per cycle over a 128-bit dividend, with a 64-bit remainder.
  logic [127:0] num_q, num_d;
  logic [63:0]  rem_q, rem_d;
  logic [63:0]  dq_q, dq_d;
  logic [63:0]  db_q, db_d;
  logic         dover_q, dover_d;
  logic         dneg_q, dneg_d;
  logic [7:0]   dcnt_q, dcnt_d;
  logic         mact_q, mact_d, dact_q, dact_d, dfin_q, dfin_d;
  logic signed [47:0] res_q, res_d;

  logic [127:0] shifted;
  logic [64:0]  rtry;
  logic [63:0]  qn;
  logic [63:0]  amag;
  logic [127:0] dividend;

  always_comb begin
    mm_d = mm_q; mb_d = mb_q; acc_d = acc_q; mcnt_d = mcnt_q; msh_d = msh_q;
    mneg_d = mneg_q; num_d = num_q; rem_d = rem_q; dq_d = dq_q; db_d = db_q;
    dover_d = dover_q; dneg_d = dneg_q; dcnt_d = dcnt_q; mact_d = mact_q;
    dact_d = dact_q; dfin_d = 1'b0; res_d = res_q;
    shifted = '0; rtry = '0; qn = '0; dividend = '0;
    amag = '0;
    if (mul_start_i) begin
      amag = mul_a_i[63] ? 64'(-mul_a_i) : 64'(mul_a_i);
      mm_d = amag; mb_d = mul_b_i; acc_d = '0; mcnt_d = '0;
      msh_d = mul_sh_i; mneg_d = mul_a_i[63]; mact_d = 1'b1;
    end else if (mact_q) begin
      acc_d = acc_q + ((128'(mm_q) * 128'(mb_q[15:0])) << (7'(mcnt_q) << 4));
      mb_d = mb_q >> 16;
      mcnt_d = mcnt_q + 3'd1;
      if (mcnt_q == 3'd3) begin
        mact_d = 1'b0;
        shifted = acc_d >> msh_q;
        res_d = wapc_pkg::from_mag(shifted[63:0], shifted[127:64] != '0, mneg_q);
      end
    end
    if (div_start_i) begin
      amag = div_a_i[63] ? 64'(-div_a_i) : 64'(div_a_i);
      dividend = {64'd0, amag} << wapc_pkg::FracBits;
      num_d = dividend; rem_d = '0; dq_d = '0; db_d = div_b_i;
      dover_d = 1'b0; dneg_d = div_a_i[63]; dcnt_d = 8'd128; dact_d = 1'b1;
    end else if (dact_q) begin
      rtry = {rem_q, num_q[127]};
      qn = dq_q;
      if (rtry >= 65'(db_q)) begin
        rem_d = 64'(rtry - 65'(db_q));
        qn = {dq_q[62:0], 1'b1};
      end else begin
        rem_d = rtry[63:0];
        qn = {dq_q[62:0], 1'b0};
      end
      if (!dover_q) begin
        dq_d = qn;
        if (qn > 64'hFFFF_FFFF_FFFF) dover_d = 1'b1;
      end
      num_d = num_q << 1;
      dcnt_d = dcnt_q - 8'd1;
      if (dcnt_q == 8'd1) begin
        dact_d = 1'b0;
        dfin_d = 1'b1;
      end
    end
    if (dfin_q) res_d = wapc_pkg::from_mag(dq_q, dover_q, dneg_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mact_q <= 1'b0; dact_q <= 1'b0; dfin_q <= 1'b0;
    end else begin
      mact_q <= mact_d; dact_q <= dact_d; dfin_q <= dfin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mm_q <= mm_d; mb_q <= mb_d; acc_q <= acc_d; mcnt_q <= mcnt_d; msh_q <= msh_d;
    mneg_q <= mneg_d; num_q <= num_d; rem_q <= rem_d; dq_q <= dq_d; db_q <= db_d;
    dover_q <= dover_d; dneg_q <= dneg_d; dcnt_q <= dcnt_d; res_q <= res_d;
  end

  assign busy_o = mact_q | dact_q | dfin_q | mul_start_i | div_start_i;
  assign result_o = res_q;
endmodule
`default_nettype wire

// ===== rtl/wapc_ctrl.sv =====
// Controller: sequences one control step through the shared multiply and
// divide units of wapc_datapath and holds the piston state. Uses wapc_pkg.
`default_nettype none
module wapc_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire wapc_pkg::cfg_t     cfg_i,
  input  wire logic               home_load_i,
  input  wire logic signed [47:0] home_value_i,
  input  wire logic               start_i,
  input  wire wapc_pkg::in_beat_t beat_i,
  input  wire logic               res_free_i,
  output logic                    done_o,
  output wapc_pkg::out_beat_t     res_o,
  output logic                    mul_start_o,
  output logic signed [63:0]      mul_a_o,
  output logic [63:0]             mul_b_o,
  output logic [5:0]              mul_sh_o,
  output logic                    div_start_o,
  output logic signed [63:0]      div_a_o,
  output logic [63:0]             div_b_o,
  input  wire logic               busy_i,
  input  wire logic signed [47:0] result_i
);
  typedef enum logic [4:0] {
    S_IDLE, S_UT, S_UR, S_HALF, S_DRIFT, S_RAMP_DIV, S_RAMP_POW, S_RAMP_LIM,
    S_RAMP_NEXT, S_VEL, S_ACC, S_CHK, S_LD1, S_LD2, S_LVD, S_DX2DIV,
    S_FINISH, S_WAIT
  } state_e;

  state_e state_q, ret_q;
  logic signed [47:0] pos_q, pvel_q, lvel_q;
  logic [47:0] dstart_q;
  logic drun_q, dpos_q, lvalid_q;
  wapc_pkg::in_beat_t b_q;
  logic [32:0] dt_q;
  logic after_q, clamp_q;
  logic signed [47:0] ut_q, up_q, mov_q, vel_q, t1_q;
  logic [47:0] el_q, tlen_q, ft_q, pw_q;
  logic [48:0] tc_q;
  logic [3:0] p_q, k_q;
  logic rsel_q;
  logic signed [47:0] rmp0_q;

  logic signed [63:0] xp, up_sum, ramp_diff, dx2_sum, pos_sum;
  logic [63:0] xpm;
  logic [47:0] el_w;
  logic [47:0] u_w;
  logic [47:0] one;
  logic [3:0] pe;

  assign one = 48'(64'd1 << wapc_pkg::FracBits);

  always_comb begin
    xp = 64'(pos_q) + 64'(b_q.planned_move) + 64'(mov_q) - 64'(cfg_i.home_position);
    xpm = xp[63] ? 64'(-xp) : 64'(xp);
    u_w = one - ft_q;
    up_sum = 64'(ut_q) + 64'(result_i);
    ramp_diff = 64'(rmp0_q) - 64'(result_i);
    dx2_sum = 64'(t1_q) + 64'(result_i);
    pos_sum = 64'(pos_q) + 64'(b_q.planned_move) +
              (b_q.disable_correction ? 64'd0 : 64'(mov_q));
    el_w = (b_q.sim_time >= dstart_q) ? b_q.sim_time - dstart_q : '0;
    pe = cfg_i.drift_power;
    if (pe == 4'd0) pe = 4'd1;
    if (pe > 4'(wapc_pkg::MaxPower)) pe = 4'(wapc_pkg::MaxPower);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; ret_q <= S_IDLE; pos_q <= '0; pvel_q <= '0;
      lvel_q <= '0; dstart_q <= '0; drun_q <= 1'b0; dpos_q <= 1'b0;
      lvalid_q <= 1'b0; done_o <= 1'b0; mul_start_o <= 1'b0;
      div_start_o <= 1'b0;
    end else begin
      done_o <= 1'b0; mul_start_o <= 1'b0; div_start_o <= 1'b0;
      if (home_load_i) pos_q <= home_value_i;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            b_q <= beat_i;
            dt_q <= (beat_i.step_length == '0) ? 33'd1 : beat_i.step_length;
            after_q <= beat_i.sim_time > cfg_i.start_time;
            clamp_q <= 1'b0; mov_q <= '0;
            div_a_o <= 64'(beat_i.planned_move);
            div_b_o <= (beat_i.step_length == '0) ? 64'd1 : 64'(beat_i.step_length);
            div_start_o <= 1'b1;
            ret_q <= S_UT; state_q <= S_WAIT;
          end
        end
        S_WAIT: if (!busy_i && !mul_start_o && !div_start_o) state_q <= ret_q;
        S_UT: begin
          ut_q <= result_i; up_q <= result_i;
          if (after_q) begin
            mul_a_o <= 64'(b_q.target_elevation) - 64'(b_q.measured_elevation);
            mul_b_o <= 64'(cfg_i.absorb_gain); mul_sh_o <= 6'(wapc_pkg::FracBits);
            mul_start_o <= 1'b1; ret_q <= S_UR; state_q <= S_WAIT;
          end else state_q <= S_DRIFT;
        end
        S_UR: begin
          up_q <= wapc_pkg::sat48(up_sum);
          mul_a_o <= 64'(wapc_pkg::sat48(up_sum)) + 64'(pvel_q);
          mul_b_o <= 64'(dt_q); mul_sh_o <= 6'(wapc_pkg::FracBits + 1);
          mul_start_o <= 1'b1; ret_q <= S_HALF; state_q <= S_WAIT;
        end
        S_HALF: begin
          mov_q <= wapc_pkg::sat48(64'(result_i) - 64'(b_q.planned_move));
          state_q <= S_DRIFT;
        end
        S_DRIFT: begin
          if (cfg_i.drift_limit == '0) state_q <= S_VEL;
          else begin
            tlen_q <= (cfg_i.drift_time == '0) ? 48'd1 : cfg_i.drift_time;
            p_q <= pe;
            if (!drun_q && xpm > 64'(cfg_i.drift_limit)) begin
              drun_q <= 1'b1; dstart_q <= b_q.sim_time; dpos_q <= xp[63];
              el_q <= '0;
              tc_q <= 49'(dt_q);
              rsel_q <= 1'b0; state_q <= S_RAMP_DIV;
            end else if (drun_q) begin
              el_q <= el_w;
              tc_q <= 49'(el_w) + 49'(dt_q);
              rsel_q <= 1'b0; state_q <= S_RAMP_DIV;
            end else state_q <= S_VEL;
          end
        end
        S_RAMP_DIV: begin
          if (el_q >= tlen_q) begin
            drun_q <= 1'b0; state_q <= S_VEL;
          end else if (tc_q >= 49'(tlen_q)) begin
            ft_q <= one; pw_q <= one; k_q <= '0; state_q <= S_RAMP_POW;
          end else begin
            div_a_o <= 64'(tc_q); div_b_o <= 64'(tlen_q); div_start_o <= 1'b1;
            pw_q <= one; k_q <= '0; ret_q <= S_RAMP_POW; state_q <= S_WAIT;
          end
        end
        S_RAMP_POW: begin
          if (ret_q == S_RAMP_POW) begin
            ft_q <= result_i; ret_q <= S_IDLE;
          end else if (k_q != '0 && ret_q == S_RAMP_LIM) begin
            pw_q <= result_i; ret_q <= S_IDLE;
          end else if (k_q == p_q) begin
            mul_a_o <= 64'(cfg_i.drift_limit); mul_b_o <= 64'(one) - 64'(pw_q);
            mul_sh_o <= 6'(wapc_pkg::FracBits); mul_start_o <= 1'b1;
            ret_q <= S_RAMP_NEXT; state_q <= S_WAIT;
          end else begin
            mul_a_o <= 64'(pw_q); mul_b_o <= 64'(u_w);
            mul_sh_o <= 6'(wapc_pkg::FracBits); mul_start_o <= 1'b1;
            k_q <= k_q + 4'd1; ret_q <= S_RAMP_LIM; state_q <= S_WAIT;
          end
        end
        S_RAMP_LIM: begin
          pw_q <= result_i; ret_q <= S_IDLE; state_q <= S_RAMP_POW;
        end
        S_RAMP_NEXT: begin
          if (!rsel_q) begin
            rmp0_q <= result_i; rsel_q <= 1'b1; tc_q <= 49'(el_q);
            state_q <= S_RAMP_DIV;
          end else begin
            mov_q <= dpos_q ? wapc_pkg::sat48(64'(mov_q) + ramp_diff)
                            : wapc_pkg::sat48(64'(mov_q) - ramp_diff);
            state_q <= S_VEL;
          end
        end
        S_VEL: begin
          div_a_o <= 64'(b_q.planned_move) + 64'(mov_q); div_b_o <= 64'(dt_q);
          div_start_o <= 1'b1; ret_q <= S_ACC; state_q <= S_WAIT;
        end
        S_ACC: begin
          vel_q <= result_i;
          if (lvalid_q) begin
            div_a_o <= 64'(result_i) - 64'(lvel_q); div_b_o <= 64'(dt_q);
            div_start_o <= 1'b1; ret_q <= S_CHK; state_q <= S_WAIT;
          end else state_q <= S_FINISH;
        end
        S_CHK: begin
          if (after_q && cfg_i.accel_limit != wapc_pkg::AccelUnlimited &&
              (result_i[47] ? 48'(-result_i) : result_i) > 48'(cfg_i.accel_limit)) begin
            mul_a_o <= result_i[47] ? -64'(cfg_i.accel_limit) : 64'(cfg_i.accel_limit);
            mul_b_o <= 64'(dt_q); mul_sh_o <= 6'(wapc_pkg::FracBits);
            mul_start_o <= 1'b1; ret_q <= S_LD1; state_q <= S_WAIT;
          end else state_q <= S_FINISH;
        end
        S_LD1: begin
          mul_a_o <= 64'(result_i); mul_b_o <= 64'(dt_q);
          mul_sh_o <= 6'(wapc_pkg::FracBits); mul_start_o <= 1'b1;
          ret_q <= S_LD2; state_q <= S_WAIT;
        end
        S_LD2: begin
          t1_q <= result_i;
          mul_a_o <= 64'(lvel_q); mul_b_o <= 64'(dt_q);
          mul_sh_o <= 6'(wapc_pkg::FracBits); mul_start_o <= 1'b1;
          ret_q <= S_LVD; state_q <= S_WAIT;
        end
        S_LVD: begin
          mov_q <= wapc_pkg::sat48(64'(wapc_pkg::sat48(dx2_sum)) - 64'(b_q.planned_move));
          div_a_o <= 64'(wapc_pkg::sat48(dx2_sum)); div_b_o <= 64'(dt_q);
          div_start_o <= 1'b1; clamp_q <= 1'b1;
          ret_q <= S_DX2DIV; state_q <= S_WAIT;
        end
        S_DX2DIV: begin
          vel_q <= result_i; state_q <= S_FINISH;
        end
        S_FINISH: begin
          if (res_free_i) begin
            pos_q <= wapc_pkg::sat48(pos_sum);
            lvel_q <= vel_q; lvalid_q <= 1'b1; pvel_q <= up_q;
            res_o.correction <= b_q.disable_correction ? '0 : mov_q;
            res_o.piston_position <= wapc_pkg::sat48(pos_sum);
            res_o.accel_clamped <= clamp_q;
            res_o.drift_active <= drun_q;
            done_o <= 1'b1; state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== dv/tb_wave_absorption_piston_correction_unit.sv =====
// Self-checking testbench for the wave absorption piston correction unit.
// Drives control steps and configuration through the top-level ports and checks
// every result beat against a predictor of its own. Depends on wapc_pkg and the top level.
`timescale 1ns / 1ps
module tb_wave_absorption_piston_correction_unit;
  localparam longint unsigned Mask48 = 64'hFFFF_FFFF_FFFF;
  localparam longint unsigned Mask47 = 64'h7FFF_FFFF_FFFF;
  localparam longint unsigned OneQ = 64'h1_0000_0000;
  localparam longint Sat48Max = 64'sh7FFF_FFFF_FFFF;
  localparam longint Sat48Min = -64'sh8000_0000_0000;
  localparam int CycleLimit = 12_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  wapc_pkg::in_beat_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  wapc_pkg::out_beat_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_index_i = wapc_pkg::RegStartTime;
  logic [47:0] cfg_data_i = '0;

  wave_absorption_piston_correction_unit dut (.*);

  always #5 clk_i = ~clk_i;

  // Configuration and state as the predictor sees them.
  longint unsigned m_start, m_gain, m_dlimit, m_dtime, m_power, m_accel;
  longint m_home, m_pos, m_vel, m_last_vel;
  longint unsigned m_drift_t0;
  bit m_drift_run, m_drift_up, m_last_valid;

  wapc_pkg::in_beat_t pending_steps[$];
  wapc_pkg::out_beat_t expected_beats[$];
  int errors = 0;
  int beats_checked = 0;
  int send_gap = 0;
  int recv_gap = 0;
  bit idle_enable = 1'b1;
  bit long_hold_done = 1'b0;
  longint cycles = 0;

  function automatic longint unsigned mag(longint a);
    return a < 0 ? 64'd0 - a : a;
  endfunction

  function automatic longint clip48(longint v);
    if (v > Sat48Max) return Sat48Max;
    if (v < Sat48Min) return Sat48Min;
    return v;
  endfunction

  function automatic longint signed_of(longint unsigned m, bit over, bit neg);
    if (neg) begin
      if (over || m > 64'h8000_0000_0000) return Sat48Min;
      return -longint'(m);
    end
    if (over || m > Mask47) return Sat48Max;
    return longint'(m);
  endfunction

  function automatic longint mul_fx(longint a, longint unsigned b, int sh);
    logic [127:0] p;
    p = ({64'd0, mag(a)} * {64'd0, b}) >> sh;
    return signed_of(p[63:0], p[127:64] != 0, a < 0);
  endfunction

  function automatic longint div_fx(longint a, longint unsigned b, int sh);
    logic [127:0] q;
    q = ({64'd0, mag(a)} << sh) / {64'd0, b};
    return signed_of(q[63:0], q > 128'(Mask48), a < 0);
  endfunction

  function automatic longint ramp_total(longint unsigned tc, longint unsigned tlen, int p);
    longint unsigned ft, u, pw;
    pw = OneQ;
    ft = (tc >= tlen) ? OneQ : longint'(div_fx(longint'(tc), tlen, wapc_pkg::FracBits));
    u = OneQ - ft;
    for (int k = 0; k < p; k++) pw = mul_fx(longint'(pw), u, wapc_pkg::FracBits);
    return mul_fx(longint'(m_dlimit), OneQ - pw, wapc_pkg::FracBits);
  endfunction

  task automatic add_step(input wapc_pkg::in_beat_t b);
    pending_steps = {pending_steps, b};
  endtask

  task automatic predict_step(input wapc_pkg::in_beat_t b);
    longint unsigned now, dt, tlen, el;
    longint xmov, tz, mz, target_v, up, mov, vel, ur, half, xp, c, acc, lim, dx2;
    bit after, clamped;
    int p;
    wapc_pkg::out_beat_t r;
    now = b.sim_time;
    dt = b.step_length;
    xmov = longint'($signed(b.planned_move));
    tz = longint'($signed(b.target_elevation));
    mz = longint'($signed(b.measured_elevation));
    after = now > m_start;
    clamped = 1'b0;
    mov = 0;
    if (dt == 0) dt = 1;
    target_v = div_fx(xmov, dt, wapc_pkg::FracBits);
    up = target_v;
    if (after) begin
      ur = mul_fx(tz - mz, m_gain, wapc_pkg::FracBits);
      up = clip48(target_v + ur);
      half = mul_fx(up + m_vel, dt, wapc_pkg::FracBits + 1);
      mov = clip48(half - xmov);
    end
    if (m_dlimit != 0) begin
      xp = m_pos + xmov + mov - m_home;
      if (!m_drift_run && mag(xp) > m_dlimit) begin
        m_drift_run = 1'b1;
        m_drift_t0 = now;
        m_drift_up = xp < 0;
      end
      if (m_drift_run) begin
        tlen = m_dtime != 0 ? m_dtime : 1;
        el = now >= m_drift_t0 ? now - m_drift_t0 : 0;
        if (el < tlen) begin
          p = int'(m_power);
          if (p == 0) p = 1;
          if (p > wapc_pkg::MaxPower) p = wapc_pkg::MaxPower;
          c = ramp_total(el + dt, tlen, p) - ramp_total(el, tlen, p);
          mov = clip48(m_drift_up ? mov + c : mov - c);
        end else begin
          m_drift_run = 1'b0;
        end
      end
    end
    vel = div_fx(xmov + mov, dt, wapc_pkg::FracBits);
    if (m_last_valid) begin
      acc = div_fx(vel - m_last_vel, dt, wapc_pkg::FracBits);
      if (after && m_accel != Mask47 && mag(acc) > m_accel) begin
        lim = acc >= 0 ? longint'(m_accel) : -longint'(m_accel);
        dx2 = clip48(mul_fx(mul_fx(lim, dt, wapc_pkg::FracBits), dt, wapc_pkg::FracBits)
                     + mul_fx(m_last_vel, dt, wapc_pkg::FracBits));
        mov = clip48(dx2 - xmov);
        vel = div_fx(dx2, dt, wapc_pkg::FracBits);
        clamped = 1'b1;
      end
    end
    m_last_vel = vel;
    m_last_valid = 1'b1;
    if (b.disable_correction) mov = 0;
    m_pos = clip48(m_pos + xmov + mov);
    m_vel = up;
    r.correction = mov[47:0];
    r.piston_position = m_pos[47:0];
    r.accel_clamped = clamped;
    r.drift_active = m_drift_run;
    expected_beats = {expected_beats, r};
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at beat %0d: %s got %h expected %h", beats_checked, what, got, want);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_enable || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  function automatic longint unsigned rand64();
    return {$urandom, $urandom};
  endfunction

  // Sender: holds a beat until it is taken, then offers the next one after a random gap that may be zero.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) predict_step(in_data_i);
      if (in_valid_i && !in_ready_o) begin
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_steps.size() != 0) begin
        in_data_i <= pending_steps.pop_front();
        in_valid_i <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver and checker, with one long hold-off to back the block up.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("unexpected beat", out_data_o.piston_position, 0);
        end else begin
          wapc_pkg::out_beat_t e;
          e = expected_beats.pop_front();
          if (out_data_o.correction !== e.correction)
            report_mismatch("correction", out_data_o.correction, e.correction);
          if (out_data_o.piston_position !== e.piston_position)
            report_mismatch("piston_position", out_data_o.piston_position, e.piston_position);
          if (out_data_o.accel_clamped !== e.accel_clamped)
            report_mismatch("accel_clamped", out_data_o.accel_clamped, e.accel_clamped);
          if (out_data_o.drift_active !== e.drift_active)
            report_mismatch("drift_active", out_data_o.drift_active, e.drift_active);
        end
        beats_checked <= beats_checked + 1;
      end
      if (!long_hold_done && beats_checked == 400) begin
        long_hold_done <= 1'b1;
        recv_gap <= 8000;
        out_ready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready_i <= 1'b0;
      end else if (out_ready_i && pick_gap() > 0) begin
        recv_gap <= pick_gap();
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input longint unsigned v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v[47:0];
    case (idx)
      wapc_pkg::RegStartTime: m_start = v & Mask48;
      wapc_pkg::RegAbsorbGain: m_gain = v & Mask47;
      wapc_pkg::RegHomePos: begin
        m_home = longint'($signed(v[47:0]));
        m_pos = m_home;
      end
      wapc_pkg::RegDriftLimit: m_dlimit = v & Mask47;
      wapc_pkg::RegDriftTime: m_dtime = v & Mask48;
      wapc_pkg::RegDriftPower: m_power = v & 64'hF;
      wapc_pkg::RegAccelLimit: m_accel = v & Mask47;
      default: begin
      end
    endcase
  endtask

  task automatic set_config(input longint unsigned st, input longint unsigned gain,
                            input longint home, input longint unsigned dlim,
                            input longint unsigned dtime, input longint unsigned pw,
                            input longint unsigned acc);
    write_reg(wapc_pkg::RegStartTime, st);
    write_reg(wapc_pkg::RegAbsorbGain, gain);
    write_reg(wapc_pkg::RegHomePos, home);
    write_reg(wapc_pkg::RegDriftLimit, dlim);
    write_reg(wapc_pkg::RegDriftTime, dtime);
    write_reg(wapc_pkg::RegDriftPower, pw);
    write_reg(wapc_pkg::RegAccelLimit, acc);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_steps.size() != 0 || in_valid_i || expected_beats.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic wapc_pkg::in_beat_t make_beat(longint unsigned t, longint unsigned dt,
                                                   longint mv, longint tz, longint mz,
                                                   bit dis);
    wapc_pkg::in_beat_t b;
    b.sim_time = t[47:0];
    b.step_length = dt[32:0];
    b.planned_move = mv[47:0];
    b.target_elevation = tz[47:0];
    b.measured_elevation = mz[47:0];
    b.disable_correction = dis;
    return b;
  endfunction

  // Mostly steady time steps with small motions; some steps are raw noise.
  task automatic queue_random(input int n, input longint unsigned t0, input int bias);
    longint unsigned t, dt;
    longint mv;
    t = t0;
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) idle_enable = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 9) == 0) begin
        add_step(make_beat(rand64(), rand64(), rand64(), rand64(),
                           rand64(), $urandom_range(0, 1)));
      end else begin
        dt = 64'd42949672 + $urandom_range(0, 1 << 24);
        if ($urandom_range(0, 49) == 0 && t > 64'd1 << 34) t = t - (64'd1 << 33);
        else t = t + dt;
        mv = longint'($urandom_range(0, 1 << 25)) - (1 << 24) + bias;
        add_step(make_beat(t, dt, mv,
                           longint'($urandom_range(0, 1 << 30)) - (1 << 29),
                           longint'($urandom_range(0, 1 << 30)) - (1 << 29),
                           $urandom_range(0, 15) == 0));
      end
    end
  endtask

  initial begin
    m_start = 0; m_gain = 0; m_home = 0; m_dlimit = 0; m_dtime = OneQ; m_power = 1;
    m_accel = Mask47; m_pos = 0; m_vel = 0; m_last_vel = 0; m_drift_t0 = 0;
    m_drift_run = 0; m_drift_up = 0; m_last_valid = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    set_config(0, OneQ, 0, 0, OneQ, 1, Mask47);
    add_step(make_beat(0, 0, 0, 0, 0, 0));
    add_step(make_beat(OneQ, OneQ, 1 << 20, 1 << 28, 0, 0));
    add_step(make_beat(Mask48, 64'h1_FFFF_FFFF, Sat48Max, Sat48Max, Sat48Min, 0));
    add_step(make_beat(Mask48, 1, Sat48Min, Sat48Min, Sat48Max, 1));
    add_step(make_beat(2 * OneQ, 0, Sat48Max, 0, 0, 0));
    add_step(make_beat(3 * OneQ, OneQ, -1, -1, 1, 1));
    queue_random(120, 4 * OneQ, 0);
    wait_idle();

    set_config(Mask48, Mask47, Sat48Min, Mask47, 0, 0, 0);
    add_step(make_beat(Mask48, OneQ, Sat48Max, 0, 0, 0));
    add_step(make_beat(0, 0, Sat48Min, Sat48Max, Sat48Min, 0));
    add_step(make_beat(OneQ, OneQ >> 4, 1 << 30, 0, 0, 1));
    queue_random(120, 0, 0);
    wait_idle();

    set_config(0, OneQ >> 1, 1 << 20, 1 << 28, 1 << 30, 8, Mask47);
    add_step(make_beat(OneQ, OneQ >> 6, 1 << 30, 0, 0, 0));
    add_step(make_beat(OneQ >> 1, OneQ >> 6, 0, 0, 0, 0));
    add_step(make_beat(2 * OneQ, OneQ >> 6, 0, 0, 0, 0));
    queue_random(120, OneQ, 1 << 23);
    wait_idle();

    set_config(2 * OneQ, OneQ << 2, -(1 << 22), 1 << 27, Mask48, 15, 64'd1 << 34);
    queue_random(120, OneQ, -(1 << 23));
    wait_idle();

    set_config(OneQ, OneQ, 0, 0, OneQ, 9, 64'd1 << 36);
    queue_random(120, 2 * OneQ, 1 << 22);
    wait_idle();

    set_config(0, OneQ >> 2, Sat48Max, 1 << 29, OneQ, 3, 0);
    queue_random(120, OneQ, -(1 << 22));
    wait_idle();

    set_config(rand64(), rand64(), rand64(), rand64(), rand64(), $urandom_range(0, 15),
               rand64());
    queue_random(120, rand64() & Mask48 >> 2, 0);
    wait_idle();

    set_config($urandom_range(0, 8) * OneQ, $urandom_range(1, 8) * (OneQ >> 2),
               longint'($urandom_range(0, 1 << 26)), 64'd1 << $urandom_range(24, 30),
               OneQ >> $urandom_range(0, 3), $urandom_range(1, 8),
               64'd1 << $urandom_range(32, 38));
    queue_random(200, OneQ, 1 << 23);
    wait_idle();

    repeat (2000) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
